FILE: rtl/tmh_pkg.sv
// shared types, codes and helpers for the timer min-heap
package tmh_pkg;

    localparam int unsigned CAPACITY_DEF = 32;
    localparam int unsigned ID_COUNT_DEF = 256;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned ID_W         = 8;
    localparam int unsigned CNT_W        = 6;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] ST_EXPIRED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   tid;
    } t_slot;

    // id modulo the id count, restoring remainder one bit a step
    function automatic logic [ID_W-1:0] id_wrap(input logic [ID_W-1:0] id,
                                                input int unsigned cnt);
        logic [31:0] r;
        logic [31:0] d;
        r = 32'(id);
        for (int k = ID_W - 1; k >= 0; k--) begin
            d = 32'(cnt) << k;
            if (((k == 0) || (cnt < (32'd1 << (32 - k)))) && (r >= d)) begin
                r = r - d;
            end
        end
        return r[ID_W-1:0];
    endfunction

endpackage

FILE: rtl/tmh_in_if.sv
// request channel: operation, timer id, expiry and current time
interface tmh_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [tmh_pkg::ID_W-1:0]      timer_id;
    logic [tmh_pkg::TIME_W-1:0]    expire_time;
    logic [tmh_pkg::TIME_W-1:0]    now;

    modport source (output valid, operation, timer_id, expire_time, now, input ready);
    modport sink   (input valid, operation, timer_id, expire_time, now, output ready);
endinterface

FILE: rtl/tmh_out_if.sv
// result channel: status, reported timer and heap summary
interface tmh_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [tmh_pkg::ID_W-1:0]      expired_id;
    logic [tmh_pkg::TIME_W-1:0]    expired_time;
    logic                          last;
    logic [tmh_pkg::CNT_W-1:0]     entry_count;
    logic [tmh_pkg::TIME_W-1:0]    next_expire;
    logic                          heap_empty;

    modport source (output valid, status, expired_id, expired_time, last, entry_count,
                    next_expire, heap_empty, input ready);
    modport sink   (input valid, status, expired_id, expired_time, last, entry_count,
                    next_expire, heap_empty, output ready);
endinterface

FILE: rtl/tmh_heap_ram.sv
// heap slot memory with registered read and a copy of the root slot
module tmh_heap_ram #(
    parameter int unsigned CAPACITY = tmh_pkg::CAPACITY_DEF,
    localparam int unsigned AW = $clog2(CAPACITY)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  tmh_pkg::t_slot      i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output tmh_pkg::t_slot      o_rdata,
    output tmh_pkg::t_slot      o_root
);

    tmh_pkg::t_slot r_mem [CAPACITY];
    tmh_pkg::t_slot r_rdata;
    tmh_pkg::t_slot r_root;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we && (i_waddr == '0)) begin
            r_root <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
    assign o_root  = r_root;

endmodule

FILE: rtl/tmh_flag_ram.sv
// cancel flag memory, cleared by a sweep after reset
module tmh_flag_ram #(
    parameter int unsigned ID_COUNT = tmh_pkg::ID_COUNT_DEF,
    localparam int unsigned FW = $clog2(ID_COUNT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [FW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [FW-1:0] i_raddr,
    output logic          o_rdata,
    output logic          o_ready
);

    logic          r_mem [ID_COUNT];
    logic          r_rdata;
    logic          r_busy;
    logic [FW-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + FW'(1);
            if (r_idx == FW'(ID_COUNT - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_idx] <= 1'b0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_busy;

endmodule

FILE: rtl/timer_min_heap.sv
// Timer queue kept as a binary min-heap on expiry time. A sequencer drives one shared
// comparator and one heap memory (one access per cycle, registered read). Insert sifts
// the new timer up level by level; cancel sets the cancel flag of its id; a tick pops
// each expired timer and sifts the last slot down from the root. After reset a sweep
// clears the cancel flags, during which no request is taken. Results wait in an output
// register; each request ends with one beat that has last set.
module timer_min_heap #(
    parameter int unsigned CAPACITY = tmh_pkg::CAPACITY_DEF,
    parameter int unsigned ID_COUNT = tmh_pkg::ID_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmh_in_if.sink      i_req,
    tmh_out_if.source   o_rsp
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned SW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = AW + 2;
    localparam int unsigned FW = $clog2(ID_COUNT);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_UP_RD   = 11'b000_0000_0010,
        S_UP_CMP  = 11'b000_0000_0100,
        S_TK_CHK  = 11'b000_0000_1000,
        S_TK_LAST = 11'b000_0001_0000,
        S_DN_L    = 11'b000_0010_0000,
        S_DN_R    = 11'b000_0100_0000,
        S_DN_CMP  = 11'b000_1000_0000,
        S_DN_MV   = 11'b001_0000_0000,
        S_POPEMIT = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_hole, n_hole;
    logic [SW-1:0] r_size, n_size;
    tmh_pkg::t_slot r_item, n_item;
    logic [tmh_pkg::TIME_W-1:0] r_now, n_now;
    tmh_pkg::t_slot r_child, n_child;
    logic [AW-1:0] r_cidx, n_cidx;
    logic r_has_r, n_has_r;
    tmh_pkg::t_slot r_mov, n_mov;
    tmh_pkg::t_slot r_top, n_top;
    logic r_top_can, n_top_can;
    logic [1:0] r_fin_st, n_fin_st;

    logic r_ov, n_ov;
    logic [1:0] r_o_st, n_o_st;
    logic [tmh_pkg::ID_W-1:0] r_o_id, n_o_id;
    logic [tmh_pkg::TIME_W-1:0] r_o_time, n_o_time;
    logic r_o_last, n_o_last;
    logic [tmh_pkg::CNT_W-1:0] r_o_cnt, n_o_cnt;
    logic [tmh_pkg::TIME_W-1:0] r_o_next, n_o_next;
    logic r_o_empty, n_o_empty;

    logic h_we, h_re;
    logic [AW-1:0] h_waddr, h_raddr;
    tmh_pkg::t_slot h_wdata, h_rdata, h_root;
    logic f_we, f_wd, f_re, f_rd, f_ready;
    logic [FW-1:0] f_waddr, f_raddr;

    logic [tmh_pkg::TIME_W-1:0] cmp_a, cmp_b;
    logic cmp_lt;
    logic in_acc, out_free, load_out;
    logic [AW-1:0] hole_m1, parent;
    logic [IW-1:0] left_w, right_w, size_w;

    tmh_heap_ram #(.CAPACITY(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_re(h_re), .i_raddr(h_raddr), .o_rdata(h_rdata), .o_root(h_root)
    );

    tmh_flag_ram #(.ID_COUNT(ID_COUNT)) u_flags (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wd),
        .i_re(f_re), .i_raddr(f_raddr), .o_rdata(f_rd), .o_ready(f_ready)
    );

    assign i_req.ready = (r_state == S_IDLE) && f_ready;
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_ov || o_rsp.ready;

    assign cmp_lt  = cmp_a < cmp_b;
    assign hole_m1 = r_hole - AW'(1);
    assign parent  = hole_m1 >> 1;
    assign left_w  = {1'b0, r_hole, 1'b1};
    assign right_w = left_w + IW'(1);
    assign size_w  = IW'(r_size);

    always_comb begin
        n_state = r_state; n_hole = r_hole; n_size = r_size; n_item = r_item;
        n_now = r_now; n_child = r_child; n_cidx = r_cidx; n_has_r = r_has_r;
        n_mov = r_mov; n_top = r_top; n_top_can = r_top_can; n_fin_st = r_fin_st;
        h_we = 1'b0; h_waddr = r_hole; h_wdata = r_item; h_re = 1'b0; h_raddr = parent;
        f_we = 1'b0; f_wd = 1'b0;
        f_waddr = FW'(tmh_pkg::id_wrap(i_req.timer_id, ID_COUNT));
        f_re = 1'b0;
        f_raddr = FW'(tmh_pkg::id_wrap(h_root.tid, ID_COUNT));
        cmp_a = r_item.expiry; cmp_b = h_rdata.expiry;
        load_out = 1'b0;
        n_o_st = tmh_pkg::ST_DONE; n_o_id = '0; n_o_time = '0; n_o_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item = '{expiry: i_req.expire_time, tid: i_req.timer_id};
                    n_now  = i_req.now;
                    case (i_req.operation)
                        tmh_pkg::OP_INSERT: begin
                            if (r_size >= SW'(CAPACITY)) begin
                                n_fin_st = tmh_pkg::ST_REJECTED;
                                n_state  = S_EMIT;
                            end else begin
                                f_we     = 1'b1;
                                n_hole   = AW'(r_size);
                                n_size   = r_size + SW'(1);
                                n_fin_st = tmh_pkg::ST_INSERTED;
                                n_state  = S_UP_RD;
                            end
                        end
                        tmh_pkg::OP_CANCEL: begin
                            f_we     = 1'b1;
                            f_wd     = 1'b1;
                            n_fin_st = tmh_pkg::ST_DONE;
                            n_state  = S_EMIT;
                        end
                        tmh_pkg::OP_TICK: begin
                            n_state = S_TK_CHK;
                        end
                        default: begin
                            n_fin_st = tmh_pkg::ST_DONE;
                            n_state  = S_EMIT;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_hole == '0) begin
                    h_we    = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    h_re    = 1'b1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                h_we = 1'b1;
                if (cmp_lt) begin
                    h_wdata = h_rdata;
                    n_hole  = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_TK_CHK: begin
                cmp_a = r_now;
                cmp_b = h_root.expiry;
                if ((r_size == '0) || cmp_lt) begin
                    n_fin_st = tmh_pkg::ST_DONE;
                    n_state  = S_EMIT;
                end else begin
                    n_top   = h_root;
                    n_size  = r_size - SW'(1);
                    h_re    = 1'b1;
                    h_raddr = AW'(r_size - SW'(1));
                    f_re    = 1'b1;
                    n_state = S_TK_LAST;
                end
            end
            S_TK_LAST: begin
                n_mov     = h_rdata;
                n_hole    = '0;
                n_top_can = f_rd;
                n_state   = S_DN_L;
            end
            S_DN_L: begin
                if (left_w >= size_w) begin
                    h_we    = 1'b1;
                    h_wdata = r_mov;
                    n_state = S_POPEMIT;
                end else begin
                    h_re    = 1'b1;
                    h_raddr = AW'(left_w);
                    n_cidx  = AW'(left_w);
                    n_has_r = right_w < size_w;
                    n_state = S_DN_R;
                end
            end
            S_DN_R: begin
                n_child = h_rdata;
                h_re    = r_has_r;
                h_raddr = r_cidx + AW'(1);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmp_a = h_rdata.expiry;
                cmp_b = r_child.expiry;
                if (r_has_r && cmp_lt) begin
                    n_child = h_rdata;
                    n_cidx  = r_cidx + AW'(1);
                end
                n_state = S_DN_MV;
            end
            S_DN_MV: begin
                cmp_a = r_child.expiry;
                cmp_b = r_mov.expiry;
                h_we  = 1'b1;
                if (cmp_lt) begin
                    h_wdata = r_child;
                    n_hole  = r_cidx;
                    n_state = S_DN_L;
                end else begin
                    h_wdata = r_mov;
                    n_state = S_POPEMIT;
                end
            end
            S_POPEMIT: begin
                if (r_top_can) begin
                    n_state = S_TK_CHK;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_o_st   = tmh_pkg::ST_EXPIRED;
                    n_o_id   = r_top.tid;
                    n_o_time = r_top.expiry;
                    n_o_last = 1'b0;
                    n_state  = S_TK_CHK;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_o_st   = r_fin_st;
                    if (r_fin_st != tmh_pkg::ST_DONE) begin
                        n_o_id   = r_item.tid;
                        n_o_time = r_item.expiry;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_o_cnt   = tmh_pkg::CNT_W'(r_size);
        n_o_empty = (r_size == '0);
        n_o_next  = (r_size == '0) ? '0 : h_root.expiry;
        n_ov      = load_out ? 1'b1 : (o_rsp.ready ? 1'b0 : r_ov);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole <= n_hole; r_item <= n_item; r_now <= n_now; r_child <= n_child;
        r_cidx <= n_cidx; r_has_r <= n_has_r; r_mov <= n_mov; r_top <= n_top;
        r_top_can <= n_top_can; r_fin_st <= n_fin_st;
        if (load_out) begin
            r_o_st <= n_o_st; r_o_id <= n_o_id; r_o_time <= n_o_time;
            r_o_last <= n_o_last; r_o_cnt <= n_o_cnt; r_o_next <= n_o_next;
            r_o_empty <= n_o_empty;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_st;
    assign o_rsp.expired_id   = r_o_id;
    assign o_rsp.expired_time = r_o_time;
    assign o_rsp.last         = r_o_last;
    assign o_rsp.entry_count  = r_o_cnt;
    assign o_rsp.next_expire  = r_o_next;
    assign o_rsp.heap_empty   = r_o_empty;

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= SW'(CAPACITY))
        else $error("heap size beyond capacity");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && (n_o_st == tmh_pkg::ST_REJECTED)) |-> (r_size == SW'(CAPACITY)))
        else $error("insert rejected while heap has room");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_req.ready)
        else $error("request taken while previous one still in progress");

endmodule

FILE: test/timer_min_heap_tb.sv
// self-checking testbench for the timer min-heap: directed and random requests, scored results
`timescale 1ns / 1ps

module timer_min_heap_tb;

    localparam int unsigned HEAP_CAP = tmh_pkg::CAPACITY_DEF;
    localparam int unsigned FLAG_CNT = tmh_pkg::ID_COUNT_DEF;

    typedef struct {
        logic [1:0]                 status;
        logic [tmh_pkg::ID_W-1:0]   tid;
        logic [tmh_pkg::TIME_W-1:0] expiry;
        logic                       last;
        logic [tmh_pkg::CNT_W-1:0]  count;
        logic [tmh_pkg::TIME_W-1:0] root_time;
        logic                       empty;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    tmh_in_if  req_if ();
    tmh_out_if rsp_if ();

    timer_min_heap u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // model state
    tmh_pkg::t_slot heap_model [HEAP_CAP];
    int unsigned    heap_count;
    bit             cancel_flag [FLAG_CNT];

    t_result     pending_q [$];
    int          error_count;
    int unsigned stall_left;
    bit          hold_sink;
    bit          idle_on;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void push_result(input logic [1:0] st,
                                        input logic [tmh_pkg::ID_W-1:0] id,
                                        input logic [tmh_pkg::TIME_W-1:0] t, input logic lst);
        t_result r;
        r.status    = st;
        r.tid       = (st == tmh_pkg::ST_DONE) ? '0 : id;
        r.expiry    = (st == tmh_pkg::ST_DONE) ? '0 : t;
        r.last      = lst;
        r.count     = tmh_pkg::CNT_W'(heap_count);
        r.root_time = heap_count != 0 ? heap_model[0].expiry : '0;
        r.empty     = heap_count == 0;
        pending_q.push_back(r);
    endfunction

    function automatic void heap_sift_down();
        int unsigned    hole;
        int unsigned    child;
        tmh_pkg::t_slot moving;
        hole   = 0;
        moving = heap_model[0];
        while (hole * 2 + 1 < heap_count) begin
            child = hole * 2 + 1;
            if (child + 1 < heap_count &&
                heap_model[child + 1].expiry < heap_model[child].expiry) child++;
            if (heap_model[child].expiry < moving.expiry) begin
                heap_model[hole] = heap_model[child];
                hole = child;
            end else begin
                break;
            end
        end
        heap_model[hole] = moving;
    endfunction

    function automatic void predict_request(input logic [1:0] op,
                                            input logic [tmh_pkg::ID_W-1:0] id,
                                            input logic [tmh_pkg::TIME_W-1:0] exp_t,
                                            input logic [tmh_pkg::TIME_W-1:0] now_t);
        int unsigned    hole;
        int unsigned    parent;
        tmh_pkg::t_slot top;
        if (op == tmh_pkg::OP_INSERT) begin
            if (heap_count >= HEAP_CAP) begin
                push_result(tmh_pkg::ST_REJECTED, id, exp_t, 1'b1);
                return;
            end
            cancel_flag[id % FLAG_CNT] = 1'b0;
            hole = heap_count;
            heap_count++;
            while (hole > 0) begin
                parent = (hole - 1) / 2;
                if (heap_model[parent].expiry > exp_t) begin
                    heap_model[hole] = heap_model[parent];
                    hole = parent;
                end else begin
                    break;
                end
            end
            heap_model[hole].expiry = exp_t;
            heap_model[hole].tid    = id;
            push_result(tmh_pkg::ST_INSERTED, id, exp_t, 1'b1);
            return;
        end
        if (op == tmh_pkg::OP_CANCEL) cancel_flag[id % FLAG_CNT] = 1'b1;
        if (op == tmh_pkg::OP_TICK) begin
            while (heap_count != 0 && heap_model[0].expiry <= now_t) begin
                top = heap_model[0];
                heap_count--;
                heap_model[0] = heap_model[heap_count];
                heap_sift_down();
                if (!cancel_flag[top.tid % FLAG_CNT])
                    push_result(tmh_pkg::ST_EXPIRED, top.tid, top.expiry, 1'b0);
            end
        end
        push_result(tmh_pkg::ST_DONE, '0, '0, 1'b1);
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [tmh_pkg::ID_W-1:0] id,
                                input logic [tmh_pkg::TIME_W-1:0] exp_t,
                                input logic [tmh_pkg::TIME_W-1:0] now_t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.timer_id    <= id;
        req_if.expire_time <= exp_t;
        req_if.now         <= now_t;
        do @(posedge i_clk); while (!req_if.ready);
        predict_request(op, id, exp_t, now_t);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // result scoreboard
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected beat status", 32'(rsp_if.status), 32'd0);
            end else begin
                w = pending_q.pop_front();
                if (rsp_if.status !== w.status)
                    report("status", 32'(rsp_if.status), 32'(w.status));
                if (rsp_if.expired_id !== w.tid)
                    report("expired_id", 32'(rsp_if.expired_id), 32'(w.tid));
                if (rsp_if.expired_time !== w.expiry)
                    report("expired_time", rsp_if.expired_time, w.expiry);
                if (rsp_if.last !== w.last)
                    report("last", 32'(rsp_if.last), 32'(w.last));
                if (rsp_if.entry_count !== w.count)
                    report("entry_count", 32'(rsp_if.entry_count), 32'(w.count));
                if (rsp_if.next_expire !== w.root_time)
                    report("next_expire", rsp_if.next_expire, w.root_time);
                if (rsp_if.heap_empty !== w.empty)
                    report("heap_empty", 32'(rsp_if.heap_empty), 32'(w.empty));
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (hold_sink) begin
            rsp_if.ready <= 1'b0;
        end else if (!idle_on) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 9);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_request(tmh_pkg::OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(tmh_pkg::OP_INSERT, 8'd5, 32'hFFFF_FFFF, 32'd0);
        send_request(tmh_pkg::OP_INSERT, 8'd255, 32'd0, 32'd0);
        send_request(tmh_pkg::OP_INSERT, 8'd7, 32'd100, 32'd0);
        send_request(tmh_pkg::OP_INSERT, 8'd8, 32'd100, 32'd0);
        send_request(tmh_pkg::OP_INSERT, 8'd9, 32'd50, 32'd0);
        send_request(tmh_pkg::OP_CANCEL, 8'd7, 32'd0, 32'd0);
        send_request(tmh_pkg::OP_CANCEL, 8'd200, 32'd0, 32'd0);
        send_request(2'd3, 8'hAA, 32'h5555_AAAA, 32'hAAAA_5555);
        send_request(tmh_pkg::OP_TICK, 8'd0, 32'd0, 32'd49);
        send_request(tmh_pkg::OP_TICK, 8'd0, 32'd0, 32'd100);
        send_request(tmh_pkg::OP_INSERT, 8'd7, 32'd10, 32'd0);
        send_request(tmh_pkg::OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFE);
        send_request(tmh_pkg::OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_fill_and_stall();
        hold_sink = 1'b1;
        fork
            begin
                repeat (HEAP_CAP + 2)
                    send_request(tmh_pkg::OP_INSERT, 8'($urandom), $urandom_range(0, 1000),
                                 32'd0);
            end
            begin
                repeat (800) @(posedge i_clk);
                hold_sink = 1'b0;
            end
        join
        wait_drained();
        send_request(tmh_pkg::OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_random(input int unsigned n_items);
        logic [1:0]                 op;
        logic [tmh_pkg::TIME_W-1:0] clock_now;
        int unsigned                sel;
        clock_now = $urandom_range(0, 1000);
        repeat (n_items) begin
            sel = $urandom_range(0, 19);
            if (sel < 10) op = tmh_pkg::OP_INSERT;
            else if (sel < 13) op = tmh_pkg::OP_CANCEL;
            else if (sel < 19) op = tmh_pkg::OP_TICK;
            else op = 2'd3;
            if (op == tmh_pkg::OP_TICK) clock_now += $urandom_range(0, 60);
            if ($urandom_range(0, 9) == 0)
                send_request(op, 8'($urandom), $urandom, $urandom);
            else
                send_request(op, 8'($urandom_range(0, 15)),
                             clock_now + $urandom_range(0, 200), clock_now);
        end
        wait_drained();
    endtask

    initial begin
        error_count   = 0;
        heap_count    = 0;
        hold_sink     = 1'b0;
        idle_on       = 1'b1;
        foreach (cancel_flag[k]) cancel_flag[k] = 1'b0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.operation   = tmh_pkg::OP_TICK;
        req_if.timer_id    = '0;
        req_if.expire_time = '0;
        req_if.now         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_and_stall();
        test_random(100);
        idle_on = 1'b0;
        test_random(40);
        if (error_count == 0) $display("timer_min_heap verification clean");
        else $display("timer_min_heap verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("timer_min_heap verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/tmh_pkg.sv
rtl/tmh_in_if.sv
rtl/tmh_out_if.sv
rtl/tmh_heap_ram.sv
rtl/tmh_flag_ram.sv
rtl/timer_min_heap.sv
test/timer_min_heap_tb.sv
